@@ design/cu2d_pkg.sv @@
package cu2d_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_CAM_X      = 3'd0,
        CFG_CAM_Y      = 3'd1,
        CFG_ANGLE      = 3'd2,
        CFG_ZOOM_X     = 3'd3,
        CFG_ZOOM_Y     = 3'd4,
        CFG_RES_WIDTH  = 3'd5,
        CFG_RES_HEIGHT = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_SCALE = 2'd1,
        ST_SATURATED  = 2'd2
    } status_t;

    localparam int ZOOM_W = 24;
    localparam int DIV_STEPS = 32;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // odd sine polynomial coefficients, Q30
    localparam logic [31:0] C1  = 32'd1686629713;
    localparam logic [31:0] C3  = 32'd693598668;
    localparam logic [31:0] C5  = 32'd85569306;
    localparam logic [31:0] C7  = 32'd5026995;
    localparam logic [31:0] C9  = 32'd172272;
    localparam logic [31:0] C11 = 32'd3864;

    // horner order after the innermost term
    localparam logic [31:0] HORNER_C [5] = '{C9, C7, C5, C3, C1};

    localparam logic signed [31:0] CAM_X_RST = 32'sd62914560;
    localparam logic signed [31:0] CAM_Y_RST = 32'sd35389440;

endpackage

@@ design/camera_unproject_2d.sv @@
// Maps a screen point to a world point under a 2D camera: subtract half the
// resolution, divide each axis by its zoom, rotate by minus the angle, add the
// camera position. A new point may be started in every cycle (busy stays low);
// its result is valid while done is high. The pipeline has 39 register
// stages: the two 32-stage restoring dividers (one quotient bit per stage),
// three input stages and four stages of clamp, rotation multiply, rounding
// and camera add/saturation.
// Sine and cosine run in a free-running 8-stage unit fed by the angle register;
// they settle well before the first point started after a write reaches the
// rotation. Configuration may only be written with no point in flight.
// status: 0 ok, 1 a zoom is zero (world is 0), 2 result clamped or saturated.
module camera_unproject_2d #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  cu2d_pkg::cfg_idx_t  cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic signed [31:0]  screen_x,
    input  logic signed [31:0]  screen_y,
    output logic                done,
    output logic signed [31:0]  world_x,
    output logic signed [31:0]  world_y,
    output logic [1:0]          status
);
    import cu2d_pkg::*;

    localparam int V_W   = ((15 + FRAC_BITS > 32) ? 15 + FRAC_BITS : 32) + 1;
    localparam int NUM_W = V_W + FRAC_BITS + 1;
    localparam int HI_W  = NUM_W - 32;
    localparam int CMP_W = (HI_W > ZOOM_W) ? HI_W : ZOOM_W;
    localparam int LAT   = 3 + DIV_STEPS + 4;
    localparam int TS    = 7;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // configuration
    logic signed [31:0]      cam_x_reg, cam_y_reg;
    logic [ANGLE_BITS-1:0]   angle_reg;
    logic [ZOOM_W-1:0]       zoom_x_reg, zoom_y_reg;
    logic [15:0]             res_w_reg, res_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg  <= CAM_X_RST;
            cam_y_reg  <= CAM_Y_RST;
            angle_reg  <= '0;
            zoom_x_reg <= ZOOM_W'(65536);
            zoom_y_reg <= ZOOM_W'(65536);
            res_w_reg  <= 16'd1920;
            res_h_reg  <= 16'd1080;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAM_X:      cam_x_reg  <= cfg_wdata;
                CFG_CAM_Y:      cam_y_reg  <= cfg_wdata;
                CFG_ANGLE:      angle_reg  <= ANGLE_BITS'(cfg_wdata[15:0]);
                CFG_ZOOM_X:     zoom_x_reg <= cfg_wdata[ZOOM_W-1:0];
                CFG_ZOOM_Y:     zoom_y_reg <= cfg_wdata[ZOOM_W-1:0];
                CFG_RES_WIDTH:  res_w_reg  <= cfg_wdata[15:0];
                CFG_RES_HEIGHT: res_h_reg  <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid bits
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
    end

    // sine / cosine unit, lane 0 sine, lane 1 cosine
    logic [30:0] tx_reg   [TS][2];
    logic [30:0] tx2_reg  [TS][2];
    logic [31:0] tt_reg   [TS][2];
    logic        tone_reg [TS][2];
    logic        tneg_reg [TS][2];
    logic signed [31:0] trig_reg [2];

    always_ff @(posedge clk)
    begin
        logic [ANGLE_BITS-1:0] a;
        logic [29:0]           xr;
        logic [30:0]           xs;
        logic [61:0]           sq;
        logic [62:0]           pr;
        logic [32:0]           r;
        logic [30:0]           m;
        for (int l = 0; l < 2; l++)
        begin
            a  = (l == 0) ? angle_reg : angle_reg + QUARTER;
            xr = {a[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};
            xs = a[ANGLE_BITS-2] ? Q30_ONE - 31'(xr) : 31'(xr);
            tx_reg[0][l]   <= xs;
            tone_reg[0][l] <= (xs >= Q30_ONE);
            tneg_reg[0][l] <= a[ANGLE_BITS-1];
            tx2_reg[0][l]  <= '0;
            tt_reg[0][l]   <= '0;

            sq = tx_reg[0][l] * tx_reg[0][l];
            tx_reg[1][l]   <= tx_reg[0][l];
            tone_reg[1][l] <= tone_reg[0][l];
            tneg_reg[1][l] <= tneg_reg[0][l];
            tx2_reg[1][l]  <= sq[60:30];
            tt_reg[1][l]   <= C11;

            for (int s = 2; s < TS; s++)
            begin
                pr = tx2_reg[s-1][l] * tt_reg[s-1][l];
                tx_reg[s][l]   <= tx_reg[s-1][l];
                tone_reg[s][l] <= tone_reg[s-1][l];
                tneg_reg[s][l] <= tneg_reg[s-1][l];
                tx2_reg[s][l]  <= tx2_reg[s-1][l];
                tt_reg[s][l]   <= HORNER_C[s-2] - pr[61:30];
            end

            pr = tx_reg[TS-1][l] * tt_reg[TS-1][l];
            r  = pr[62:30];
            if (tone_reg[TS-1][l] || r > 33'(Q30_ONE))
                m = Q30_ONE;
            else
                m = r[30:0];
            trig_reg[l] <= tneg_reg[TS-1][l] ? -$signed(32'(m)) : $signed(32'(m));
        end
    end

    // front: offset, magnitude and numerator, overflow test
    logic signed [V_W-1:0]   va_reg  [2];
    logic [NUM_W-1:0]        num_reg [2];
    logic                    nb_reg  [2];

    logic [23:0] drem_reg [2][DIV_STEPS+1];
    logic [31:0] dw_reg   [2][DIV_STEPS+1];
    logic        dneg_reg [2][DIV_STEPS+1];
    logic        dovf_reg [2][DIV_STEPS+1];

    logic signed [32:0] d_reg [2];
    logic               dclamp_reg;

    always_ff @(posedge clk)
    begin
        logic [14:0]          half;
        logic signed [31:0]   scr;
        logic [ZOOM_W-1:0]    z;
        logic [V_W-1:0]       mag;
        logic [HI_W-1:0]      hi;
        logic                 ovf;
        logic [24:0]          r2;
        logic                 ge;
        logic [31:0]          q;
        for (int l = 0; l < 2; l++)
        begin
            half = (l == 0) ? res_w_reg[15:1] : res_h_reg[15:1];
            scr  = (l == 0) ? screen_x : screen_y;
            z    = (l == 0) ? zoom_x_reg : zoom_y_reg;

            va_reg[l] <= V_W'(scr) - $signed(V_W'({half, {FRAC_BITS{1'b0}}}));

            mag = va_reg[l][V_W-1] ? V_W'(-va_reg[l]) : V_W'(va_reg[l]);
            num_reg[l] <= NUM_W'({mag, {FRAC_BITS{1'b0}}}) + NUM_W'(z >> 1);
            nb_reg[l]  <= va_reg[l][V_W-1];

            // quotient reaches 2^32 exactly when the upper part is not below z
            hi  = num_reg[l][NUM_W-1:32];
            ovf = CMP_W'(hi) >= CMP_W'(z);
            drem_reg[l][0] <= ovf ? 24'd0 : 24'(hi);
            dw_reg[l][0]   <= num_reg[l][31:0];
            dneg_reg[l][0] <= nb_reg[l];
            dovf_reg[l][0] <= ovf;

            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                r2 = {drem_reg[l][i-1], dw_reg[l][i-1][31]};
                ge = (r2 >= {1'b0, z});
                drem_reg[l][i] <= ge ? 24'(r2 - {1'b0, z}) : r2[23:0];
                dw_reg[l][i]   <= {dw_reg[l][i-1][30:0], ge};
                dneg_reg[l][i] <= dneg_reg[l][i-1];
                dovf_reg[l][i] <= dovf_reg[l][i-1];
            end

            q = dovf_reg[l][DIV_STEPS] ? 32'hFFFF_FFFF : dw_reg[l][DIV_STEPS];
            d_reg[l] <= dneg_reg[l][DIV_STEPS] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
        dclamp_reg <= dovf_reg[0][DIV_STEPS] | dovf_reg[1][DIV_STEPS];
    end

    // rotation, rounding, camera add
    logic signed [64:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic               rclamp_reg, sclamp_reg;
    logic signed [35:0] rx_reg, ry_reg;

    logic signed [31:0] world_x_reg, world_y_reg;
    logic [1:0]         status_reg;

    always_ff @(posedge clk)
    begin
        logic signed [65:0] sx, sy;
        logic signed [36:0] ax, ay;
        logic               sat;
        pxc_reg <= d_reg[0] * trig_reg[1];
        pys_reg <= d_reg[1] * trig_reg[0];
        pyc_reg <= d_reg[1] * trig_reg[1];
        pxs_reg <= d_reg[0] * trig_reg[0];
        rclamp_reg <= dclamp_reg;

        sx = 66'(pxc_reg) + 66'(pys_reg) + 66'sd536870912;
        sy = 66'(pyc_reg) - 66'(pxs_reg) + 66'sd536870912;
        rx_reg <= sx[65:30];
        ry_reg <= sy[65:30];
        sclamp_reg <= rclamp_reg;

        ax  = 37'(rx_reg) + 37'(cam_x_reg);
        ay  = 37'(ry_reg) + 37'(cam_y_reg);
        sat = sclamp_reg;
        if (zoom_x_reg == '0 || zoom_y_reg == '0)
        begin
            world_x_reg <= '0;
            world_y_reg <= '0;
            status_reg  <= ST_ZERO_SCALE;
        end
        else
        begin
            if (ax > 37'sd2147483647)
            begin
                world_x_reg <= 32'sh7FFF_FFFF;
                sat = 1'b1;
            end
            else if (ax < -37'sd2147483648)
            begin
                world_x_reg <= 32'sh8000_0000;
                sat = 1'b1;
            end
            else
                world_x_reg <= ax[31:0];
            if (ay > 37'sd2147483647)
            begin
                world_y_reg <= 32'sh7FFF_FFFF;
                sat = 1'b1;
            end
            else if (ay < -37'sd2147483648)
            begin
                world_y_reg <= 32'sh8000_0000;
                sat = 1'b1;
            end
            else
                world_y_reg <= ay[31:0];
            status_reg <= sat ? ST_SATURATED : ST_OK;
        end
    end

    assign done    = vld_reg[LAT-1];
    assign world_x = world_x_reg;
    assign world_y = world_y_reg;
    assign status  = status_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("word lost in pipeline");

    a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
        done && (zoom_x_reg == '0 || zoom_y_reg == '0)
        |-> status == ST_ZERO_SCALE && world_x == '0 && world_y == '0)
        else $error("zero zoom not flagged");

    a_ok_needs_zoom: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK |-> zoom_x_reg != '0 && zoom_y_reg != '0)
        else $error("ok status with zero zoom");
`endif

endmodule
